// ===== design/cc20_pkg.sv =====
// ChaCha20 stream cipher: shared constants, register codes and the
// controller-to-datapath command and status types. No dependencies.
`timescale 1ns / 1ps

package cc20_pkg;

   // Block function setup
   localparam int DOUBLE_ROUNDS_DEFAULT = 10;
   localparam int STEPS_PER_DROUND      = 8;   // 4 half-quarter-round steps x 2 rounds

   localparam logic [31:0] SIGMA_0 = 32'h61707865;
   localparam logic [31:0] SIGMA_1 = 32'h3320646e;
   localparam logic [31:0] SIGMA_2 = 32'h79622d32;
   localparam logic [31:0] SIGMA_3 = 32'h6b206574;

   localparam int ROT_0 = 16;
   localparam int ROT_1 = 12;
   localparam int ROT_2 = 8;
   localparam int ROT_3 = 7;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_0_7     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_8_15    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_16_23   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_24_31   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONCE_0_7   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONCE_8_11  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_COUNT = 3'd6;

   localparam logic [63:0] KEY_0_7_RESET   = 64'h0706050403020100;
   localparam logic [63:0] KEY_8_15_RESET  = 64'h0F0E0D0C0B0A0908;
   localparam logic [63:0] KEY_16_23_RESET = 64'h1716151413121110;
   localparam logic [63:0] KEY_24_31_RESET = 64'h1F1E1D1C1B1A1918;
   localparam logic [63:0] NONCE_0_7_RESET = 64'h4A00000009000000;
   localparam logic [31:0] NONCE_8_11_RESET = 32'h0;
   localparam logic [31:0] START_COUNT_RESET = 32'h0;

   // Command from controller to datapath
   typedef struct packed {
      logic       restart;    // reload block counter from start register
      logic       load;       // latch item, load working state from init words
      logic       step;       // one half-quarter-round step on all four lanes
      logic [1:0] phase;      // which of the four steps of a round
      logic       diag;       // diagonal round (rows held rotated)
      logic       finish;     // add init words back, bump block counter
      logic       emit;       // load result register
      logic       emit_held;  // result uses the latched data byte
      logic [5:0] pos;        // keystream byte position
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_free;         // result register can take a new item this cycle
   } status_type;

   // Constant left rotation of a 32-bit word
   function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
      rotl = (x << s) | (x >> (32 - s));
   endfunction

endpackage

// ===== design/cc20_ctrl.sv =====
// ChaCha20 stream cipher controller: item handshake, block generation
// sequencing, byte position and block-held flag. Uses cc20_pkg.
`timescale 1ns / 1ps

module cc20_ctrl #(
   parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_command,
   input  logic                 req_message_end,
   output logic                 req_stall,
   input  cc20_pkg::status_type status,
   output cc20_pkg::cmd_type    cmd
);

   localparam int STEPS  = cc20_pkg::STEPS_PER_DROUND * DOUBLE_ROUNDS;
   localparam int CNT_W  = $clog2(STEPS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_GEN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic             ready_ff, ready_in;
   logic [5:0]       pos_ff, pos_in;
   logic             end_ff, end_in;
   logic             accept;

   assign req_stall = !((state_ff == ST_IDLE) && status.out_free);
   assign accept    = req_valid && !req_stall;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ready_in = ready_ff;
      pos_in   = pos_ff;
      end_in   = end_ff;
      cmd      = '0;
      cmd.pos  = pos_ff;
      cmd.phase = step_ff[1:0];
      cmd.diag  = step_ff[2];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command) begin
                  cmd.restart = 1'b1;
                  ready_in    = 1'b0;
                  pos_in      = '0;
               end else if (ready_ff) begin
                  cmd.emit = 1'b1;
                  pos_in   = pos_ff + 6'd1;
                  if ((&pos_ff) || req_message_end) ready_in = 1'b0;
                  if (req_message_end) pos_in = '0;
               end else begin
                  cmd.load = 1'b1;
                  end_in   = req_message_end;
                  step_in  = '0;
                  state_in = ST_GEN;
               end
            end
         end
         ST_GEN: begin
            cmd.step = 1'b1;
            step_in  = step_ff + CNT_W'(1);
            if (step_ff == LAST_STEP) state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            ready_in   = 1'b1;
            pos_in     = '0;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            // first byte of a fresh block, once the result register is free
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_held = 1'b1;
               pos_in        = pos_ff + 6'd1;
               if (end_ff) begin
                  ready_in = 1'b0;
                  pos_in   = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         ready_ff <= 1'b0;
         pos_ff   <= '0;
         end_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         ready_ff <= ready_in;
         pos_ff   <= pos_in;
         end_ff   <= end_in;
      end
   end

endmodule

// ===== design/cc20_datapath.sv =====
// ChaCha20 stream cipher datapath: configuration registers, block counter,
// 16-word working state / keystream buffer and result register. Uses cc20_pkg.
`timescale 1ns / 1ps

module cc20_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [cc20_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cc20_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic [7:0]                          req_data_byte,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [7:0]                          rsp_result_byte,
   input  cc20_pkg::cmd_type                   cmd,
   output cc20_pkg::status_type                status
);

   logic [63:0] key_0_7_ff, key_8_15_ff, key_16_23_ff, key_24_31_ff;
   logic [63:0] nonce_0_7_ff;
   logic [31:0] nonce_8_11_ff, start_count_ff;
   logic [31:0] counter_ff;

   // Working state: rows of four words, word index = row*4 + lane
   logic [31:0] ws_ff [16];
   logic [31:0] ws_in [16];
   logic [31:0] init_w [16];
   logic [31:0] stepped [16];

   logic [7:0]  held_ff;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_byte_ff;
   logic [31:0] ks_word;
   logic [7:0]  ks_byte;
   logic [7:0]  src_byte;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_byte = rsp_byte_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // Configuration writes and block counter
   always_ff @(posedge clock) begin
      if (reset) begin
         key_0_7_ff     <= cc20_pkg::KEY_0_7_RESET;
         key_8_15_ff    <= cc20_pkg::KEY_8_15_RESET;
         key_16_23_ff   <= cc20_pkg::KEY_16_23_RESET;
         key_24_31_ff   <= cc20_pkg::KEY_24_31_RESET;
         nonce_0_7_ff   <= cc20_pkg::NONCE_0_7_RESET;
         nonce_8_11_ff  <= cc20_pkg::NONCE_8_11_RESET;
         start_count_ff <= cc20_pkg::START_COUNT_RESET;
         counter_ff     <= cc20_pkg::START_COUNT_RESET;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               cc20_pkg::CSR_KEY_0_7:     key_0_7_ff     <= csr_write_data;
               cc20_pkg::CSR_KEY_8_15:    key_8_15_ff    <= csr_write_data;
               cc20_pkg::CSR_KEY_16_23:   key_16_23_ff   <= csr_write_data;
               cc20_pkg::CSR_KEY_24_31:   key_24_31_ff   <= csr_write_data;
               cc20_pkg::CSR_NONCE_0_7:   nonce_0_7_ff   <= csr_write_data;
               cc20_pkg::CSR_NONCE_8_11:  nonce_8_11_ff  <= csr_write_data[31:0];
               cc20_pkg::CSR_START_COUNT: start_count_ff <= csr_write_data[31:0];
               default: ;
            endcase
         end
         if (cmd.restart)     counter_ff <= start_count_ff;
         else if (cmd.finish) counter_ff <= counter_ff + 32'd1;
      end
   end

   // Block input words
   always_comb begin
      init_w[0]  = cc20_pkg::SIGMA_0;
      init_w[1]  = cc20_pkg::SIGMA_1;
      init_w[2]  = cc20_pkg::SIGMA_2;
      init_w[3]  = cc20_pkg::SIGMA_3;
      init_w[4]  = key_0_7_ff[31:0];
      init_w[5]  = key_0_7_ff[63:32];
      init_w[6]  = key_8_15_ff[31:0];
      init_w[7]  = key_8_15_ff[63:32];
      init_w[8]  = key_16_23_ff[31:0];
      init_w[9]  = key_16_23_ff[63:32];
      init_w[10] = key_24_31_ff[31:0];
      init_w[11] = key_24_31_ff[63:32];
      init_w[12] = counter_ff;
      init_w[13] = nonce_0_7_ff[31:0];
      init_w[14] = nonce_0_7_ff[63:32];
      init_w[15] = nonce_8_11_ff;
   end

   // One half-quarter-round step on all four lanes; rows rotate at round end
   // so the diagonal round works down columns too.
   always_comb begin
      logic [31:0] sum;
      logic [31:0] tmp [16];
      tmp = ws_ff;
      for (int j = 0; j < 4; j++) begin
         if (!cmd.phase[0]) begin
            sum        = ws_ff[j] + ws_ff[4+j];
            tmp[j]     = sum;
            tmp[12+j]  = cmd.phase[1] ? cc20_pkg::rotl(ws_ff[12+j] ^ sum, cc20_pkg::ROT_2)
                                      : cc20_pkg::rotl(ws_ff[12+j] ^ sum, cc20_pkg::ROT_0);
         end else begin
            sum        = ws_ff[8+j] + ws_ff[12+j];
            tmp[8+j]   = sum;
            tmp[4+j]   = cmd.phase[1] ? cc20_pkg::rotl(ws_ff[4+j] ^ sum, cc20_pkg::ROT_3)
                                      : cc20_pkg::rotl(ws_ff[4+j] ^ sum, cc20_pkg::ROT_1);
         end
      end
      stepped = tmp;
      if (cmd.phase == 2'd3) begin
         for (int j = 0; j < 4; j++) begin
            if (!cmd.diag) begin
               stepped[4+j]  = tmp[4+((j+1)&3)];
               stepped[8+j]  = tmp[8+((j+2)&3)];
               stepped[12+j] = tmp[12+((j+3)&3)];
            end else begin
               stepped[4+j]  = tmp[4+((j+3)&3)];
               stepped[8+j]  = tmp[8+((j+2)&3)];
               stepped[12+j] = tmp[12+((j+1)&3)];
            end
         end
      end
   end

   // Working state next value
   always_comb begin
      ws_in = ws_ff;
      if (cmd.load) begin
         ws_in = init_w;
      end else if (cmd.step) begin
         ws_in = stepped;
      end else if (cmd.finish) begin
         for (int i = 0; i < 16; i++) ws_in[i] = ws_ff[i] + init_w[i];
      end
   end

   always_ff @(posedge clock) begin
      ws_ff <= ws_in;
      if (cmd.load) held_ff <= req_data_byte;
   end

   // Keystream byte select and result register
   assign ks_word  = ws_ff[cmd.pos[5:2]];
   assign ks_byte  = ks_word[{cmd.pos[1:0], 3'b000} +: 8];
   assign src_byte = cmd.emit_held ? held_ff : req_data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_byte_ff <= src_byte ^ ks_byte;
   end

endmodule

// ===== design/chacha20_stream_cipher.sv =====
// ChaCha20 byte-stream cipher, top level. A byte with keystream held gives its
// result in the cycle after it is taken; the next byte can be taken in that
// same cycle if the result register is free. A byte that needs a new block
// waits for the block engine: load, one step per cycle for 8*DOUBLE_ROUNDS steps,
// finish, then its result once the result register is free. Synchronous reset
// loads the default key and nonce, zeroes the block counter and holds no keystream.
`timescale 1ns / 1ps

module chacha20_stream_cipher #(
   parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [cc20_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cc20_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_command,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_message_end,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_result_byte
);

   cc20_pkg::cmd_type    cmd;
   cc20_pkg::status_type status;

   cc20_ctrl #(
      .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_command     (req_command),
      .req_message_end (req_message_end),
      .req_stall       (req_stall),
      .status          (status),
      .cmd             (cmd)
   );

   cc20_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_data_byte    (req_data_byte),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_result_byte  (rsp_result_byte),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
